### rtl/elev_pkg.sv
// Package with the shared types and codes of the elevator car controller.
package elev_pkg;

   localparam int OP_W    = 3;
   localparam int FLOOR_W = 4;
   localparam int CMD_W   = 3;
   localparam int CAR_W   = 2;

   localparam logic [OP_W-1:0] OP_START  = 3'd0;
   localparam logic [OP_W-1:0] OP_CABIN  = 3'd1;
   localparam logic [OP_W-1:0] OP_HALL   = 3'd2;
   localparam logic [OP_W-1:0] OP_ARRIVE = 3'd3;
   localparam logic [OP_W-1:0] OP_OPENED = 3'd4;
   localparam logic [OP_W-1:0] OP_CLOSED = 3'd5;

   typedef enum logic [CMD_W-1:0] {
      CMD_RESET    = 3'd0,
      CMD_CLOSE    = 3'd1,
      CMD_UP       = 3'd2,
      CMD_DOWN     = 3'd3,
      CMD_STOP     = 3'd4,
      CMD_OPEN     = 3'd5,
      CMD_LAMP_OFF = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      DIR_IDLE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   // Car control state.
   typedef enum logic [5:0] {
      CT_WAIT    = 6'b000001,
      CT_STANDBY = 6'b000010,
      CT_CLOSING = 6'b000100,
      CT_OPENING = 6'b001000,
      CT_UP      = 6'b010000,
      CT_DOWN    = 6'b100000
   } ctrl_type;

   // Sequencer state of the event processing.
   typedef enum logic [4:0] {
      SQ_IDLE   = 5'b00001,
      SQ_SCAN_A = 5'b00010,
      SQ_SCAN_B = 5'b00100,
      SQ_DECIDE = 5'b01000,
      SQ_EMIT   = 5'b10000
   } seq_type;

   // Summary of one scan over the floors.
   typedef struct packed {
      logic any;
      logic above;
      logic below;
      logic here;
   } scan_flags_type;

endpackage

### rtl/elev_if.sv
// Valid/ready channel interfaces for event words and command words.
interface elev_req_if;
   import elev_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [FLOOR_W-1:0] floor;
   logic               hall_up;

   modport source (output valid, output op, output floor, output hall_up, input ready);
   modport sink   (input valid, input op, input floor, input hall_up, output ready);
endinterface

interface elev_rsp_if;
   import elev_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [FLOOR_W-1:0] cmd_floor;
   logic [CAR_W-1:0]   car;
   logic               last;

   modport source (output valid, output command, output cmd_floor, output car, output last,
                   input ready);
   modport sink   (input valid, input command, input cmd_floor, input car, input last,
                   output ready);
endinterface

### rtl/elevator_car_controller_top.sv
// Top level of the collective-scan elevator car controller for one car.
// Sequence: an event word is accepted, then two scans over all floors run (none while waiting
// for start-up), then a decision is taken, then the command words go out as the sink takes them.
// No new event word is taken until every command of the previous one has gone out; the
// shared one-floor-per-cycle scan unit runs both scans.
// Reset (synchronous, active high) returns the car to waiting for start-up at floor 0,
// door closed, direction idle, no requests, car identity 0.
module elevator_car_controller_top #(
   parameter int FLOORS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   elev_req_if.sink               req_ch,
   elev_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [elev_pkg::CAR_W-1:0] csr_wdata
);
   import elev_pkg::*;

   localparam int FLW = (FLOORS > 1) ? $clog2(FLOORS) : 1;
   // Width wide enough to compare a scan index with a car floor.
   localparam int CW  = (FLW > FLOOR_W) ? FLW : FLOOR_W;

   // Architectural state of the car.
   ctrl_type           ctrl_ff, ctrl_in;
   dir_type            dir_ff, dir_in;
   logic [FLOOR_W-1:0] car_floor_ff, car_floor_in;
   logic               door_open_ff, door_open_in;
   logic [FLOORS-1:0]  cab_ff, cab_in;
   logic [FLOORS-1:0]  up_ff, up_in;
   logic [FLOORS-1:0]  dn_ff, dn_in;
   logic [CAR_W-1:0]   car_id_ff;

   // Sequencer and scan unit.
   seq_type            seq_ff, seq_in;
   logic               start_ff, start_in;
   logic               arrived_ff, arrived_in;
   dir_type            pass_dir_ff, pass_dir_in;
   logic [FLW-1:0]     idx_ff, idx_in;
   logic               seen_ff, seen_in;
   scan_flags_type     acc_ff, acc_in;
   scan_flags_type     scan_a_ff, scan_a_in;

   // Command list of the current event.
   cmd_type            cmd_ff [3];
   cmd_type            cmd_in [3];
   logic [1:0]         cnt_ff, cnt_in;
   logic [1:0]         emit_ff, emit_in;

   // Per-floor evaluation of the scan unit.
   logic               cab_b, up_b, dn_b;
   logic               tgt;
   logic               step_seen;
   logic               last_step;
   logic [CW-1:0]      idx_w, floor_w;
   scan_flags_type     step_acc;

   logic               req_fire;
   logic [FLOORS-1:0]  req_mask;
   logic [FLOORS-1:0]  car_mask;
   logic               may_up, may_down;
   logic               emit_last;

   assign req_ch.ready = (seq_ff == SQ_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // A floor beyond the vector shifts out and so sets or clears nothing.
   assign req_mask = FLOORS'(1) << req_ch.floor;
   assign car_mask = FLOORS'(1) << car_floor_ff;

   // The scan unit looks at one floor per cycle. Moving up, a down call counts only
   // when no call of either kind lies above it, so that pass runs from the top and
   // remembers what it has seen. Moving down, an up call counts only when no up call
   // lies below it, so that pass runs from the bottom.
   assign cab_b   = cab_ff[idx_ff];
   assign up_b    = up_ff[idx_ff];
   assign dn_b    = dn_ff[idx_ff];
   assign idx_w   = CW'(idx_ff);
   assign floor_w = CW'(car_floor_ff);

   always_comb begin
      unique case (pass_dir_ff)
         DIR_UP: begin
            tgt       = up_b || cab_b || (dn_b && !seen_ff);
            step_seen = seen_ff || up_b || dn_b;
         end
         DIR_DOWN: begin
            tgt       = dn_b || cab_b || (up_b && !seen_ff);
            step_seen = seen_ff || up_b;
         end
         default: begin
            tgt       = cab_b || up_b || dn_b;
            step_seen = seen_ff;
         end
      endcase
   end

   always_comb begin
      step_acc.any   = acc_ff.any   || tgt;
      step_acc.above = acc_ff.above || (tgt && (idx_w > floor_w));
      step_acc.below = acc_ff.below || (tgt && (idx_w < floor_w));
      step_acc.here  = acc_ff.here  || (tgt && (idx_w == floor_w));
   end

   assign last_step = (pass_dir_ff == DIR_UP) ? (idx_ff == '0)
                                              : (idx_ff == FLW'(FLOORS - 1));

   // A search above or below is meaningful only for a matching direction.
   assign may_up    = (dir_ff == DIR_UP)   || (dir_ff == DIR_IDLE);
   assign may_down  = (dir_ff == DIR_DOWN) || (dir_ff == DIR_IDLE);

   always_comb begin
      seq_in       = seq_ff;
      ctrl_in      = ctrl_ff;
      dir_in       = dir_ff;
      car_floor_in = car_floor_ff;
      door_open_in = door_open_ff;
      cab_in       = cab_ff;
      up_in        = up_ff;
      dn_in        = dn_ff;
      start_in     = start_ff;
      arrived_in   = arrived_ff;
      pass_dir_in  = pass_dir_ff;
      idx_in       = idx_ff;
      seen_in      = seen_ff;
      acc_in       = acc_ff;
      scan_a_in    = scan_a_ff;
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      emit_in      = emit_ff;

      unique case (seq_ff)
         SQ_IDLE: begin
            if (req_fire) begin
               start_in   = (req_ch.op == OP_START);
               arrived_in = (req_ch.op == OP_ARRIVE);
               cnt_in     = 2'd0;
               // Request, floor and door bookkeeping comes first.
               unique case (req_ch.op)
                  OP_CABIN: begin
                     if (req_ch.floor != car_floor_ff || !door_open_ff) begin
                        cab_in = cab_ff | req_mask;
                     end else begin
                        // Button of the floor where the door stands open.
                        cmd_in[0] = CMD_LAMP_OFF;
                        cnt_in    = 2'd1;
                     end
                  end
                  OP_HALL: begin
                     if (req_ch.floor != car_floor_ff || !door_open_ff) begin
                        if (req_ch.hall_up) begin
                           up_in = up_ff | req_mask;
                        end else begin
                           dn_in = dn_ff | req_mask;
                        end
                     end
                  end
                  OP_ARRIVE: car_floor_in = req_ch.floor;
                  OP_OPENED: door_open_in = 1'b1;
                  OP_CLOSED: door_open_in = 1'b0;
                  default: ;
               endcase
               // First scan direction follows the control state.
               unique case (ctrl_ff)
                  CT_UP:                 pass_dir_in = DIR_UP;
                  CT_DOWN:               pass_dir_in = DIR_DOWN;
                  CT_CLOSING, CT_OPENING: pass_dir_in = dir_ff;
                  default:               pass_dir_in = DIR_IDLE;
               endcase
               idx_in  = '0;
               seen_in = 1'b0;
               acc_in  = '0;
               if (ctrl_ff == CT_UP) begin
                  idx_in = FLW'(FLOORS - 1);
               end else if ((ctrl_ff == CT_CLOSING || ctrl_ff == CT_OPENING)
                            && dir_ff == DIR_UP) begin
                  idx_in = FLW'(FLOORS - 1);
               end
               seq_in = (ctrl_ff == CT_WAIT) ? SQ_DECIDE : SQ_SCAN_A;
            end
         end
         SQ_SCAN_A: begin
            acc_in  = step_acc;
            seen_in = step_seen;
            if (last_step) begin
               scan_a_in   = step_acc;
               pass_dir_in = DIR_IDLE;
               idx_in      = '0;
               seen_in     = 1'b0;
               acc_in      = '0;
               seq_in      = SQ_SCAN_B;
            end else if (pass_dir_ff == DIR_UP) begin
               idx_in = idx_ff - 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         SQ_SCAN_B: begin
            acc_in  = step_acc;
            seen_in = step_seen;
            if (last_step) begin
               seq_in = SQ_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         SQ_DECIDE: begin
            // First scan results are in scan_a_ff, the idle scan results in acc_ff.
            unique case (ctrl_ff)
               CT_WAIT: begin
                  if (start_ff) begin
                     cmd_in[cnt_ff] = CMD_RESET;
                     cnt_in         = cnt_ff + 1'b1;
                     ctrl_in        = CT_STANDBY;
                  end
               end
               CT_STANDBY: begin
                  dir_in = DIR_IDLE;
                  if (scan_a_ff.any) begin
                     cmd_in[cnt_ff] = CMD_CLOSE;
                     cnt_in         = cnt_ff + 1'b1;
                     ctrl_in        = CT_CLOSING;
                  end
               end
               CT_CLOSING: begin
                  if (!door_open_ff) begin
                     if ((may_up && scan_a_ff.above) || (!(may_down && scan_a_ff.below)
                                                         && acc_ff.above)) begin
                        cmd_in[cnt_ff] = CMD_UP;
                        cnt_in         = cnt_ff + 1'b1;
                        ctrl_in        = CT_UP;
                     end else if ((may_down && scan_a_ff.below) || acc_ff.below) begin
                        cmd_in[cnt_ff] = CMD_DOWN;
                        cnt_in         = cnt_ff + 1'b1;
                        ctrl_in        = CT_DOWN;
                     end
                  end
               end
               CT_UP, CT_DOWN: begin
                  dir_in = (ctrl_ff == CT_UP) ? DIR_UP : DIR_DOWN;
                  if (arrived_ff && scan_a_ff.here) begin
                     cmd_in[0] = CMD_STOP;
                     cmd_in[1] = CMD_OPEN;
                     cmd_in[2] = CMD_LAMP_OFF;
                     cnt_in    = 2'd3;
                     cab_in    = cab_ff & ~car_mask;
                     up_in     = up_ff & ~car_mask;
                     dn_in     = dn_ff & ~car_mask;
                     ctrl_in   = CT_OPENING;
                  end
               end
               CT_OPENING: begin
                  if (door_open_ff) begin
                     if (scan_a_ff.any) begin
                        cmd_in[cnt_ff] = CMD_CLOSE;
                        cnt_in         = cnt_ff + 1'b1;
                        ctrl_in        = CT_CLOSING;
                     end else if (acc_ff.any) begin
                        dir_in         = DIR_IDLE;
                        cmd_in[cnt_ff] = CMD_CLOSE;
                        cnt_in         = cnt_ff + 1'b1;
                        ctrl_in        = CT_CLOSING;
                     end else begin
                        ctrl_in = CT_STANDBY;
                     end
                  end
               end
               default: ctrl_in = CT_WAIT;
            endcase
            emit_in = 2'd0;
            // An event that causes no command ends here.
            seq_in  = (cnt_in != 2'd0) ? SQ_EMIT : SQ_IDLE;
         end
         SQ_EMIT: begin
            if (rsp_ch.ready) begin
               if (emit_last) begin
                  seq_in = SQ_IDLE;
               end else begin
                  emit_in = emit_ff + 1'b1;
               end
            end
         end
         default: seq_in = SQ_IDLE;
      endcase
   end

   // Command words come straight from the stored list; the list holds until taken.
   assign emit_last         = (emit_ff == cnt_ff - 1'b1);
   assign rsp_ch.valid      = (seq_ff == SQ_EMIT);
   assign rsp_ch.command    = cmd_ff[emit_ff];
   assign rsp_ch.cmd_floor  = (cmd_ff[emit_ff] == CMD_LAMP_OFF) ? car_floor_ff : '0;
   assign rsp_ch.car        = car_id_ff;
   assign rsp_ch.last       = emit_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SQ_IDLE;
         ctrl_ff      <= CT_WAIT;
         dir_ff       <= DIR_IDLE;
         car_floor_ff <= '0;
         door_open_ff <= 1'b0;
         cab_ff       <= '0;
         up_ff        <= '0;
         dn_ff        <= '0;
         car_id_ff    <= '0;
         cnt_ff       <= '0;
         emit_ff      <= '0;
      end else begin
         seq_ff       <= seq_in;
         ctrl_ff      <= ctrl_in;
         dir_ff       <= dir_in;
         car_floor_ff <= car_floor_in;
         door_open_ff <= door_open_in;
         cab_ff       <= cab_in;
         up_ff        <= up_in;
         dn_ff        <= dn_in;
         cnt_ff       <= cnt_in;
         emit_ff      <= emit_in;
         if (csr_we) begin
            car_id_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      arrived_ff  <= arrived_in;
      pass_dir_ff <= pass_dir_in;
      idx_ff      <= idx_in;
      seen_ff     <= seen_in;
      acc_ff      <= acc_in;
      scan_a_ff   <= scan_a_in;
      cmd_ff      <= cmd_in;
   end

   // The controller never takes a new event while commands are pending.
   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("event accepted while commands pending");

   // An accepted event always keeps the input closed in the next cycle.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("input ready right after accept");

   // Taking the final command of an event returns the controller to idle.
   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last) |=> (!rsp_ch.valid && req_ch.ready))
      else $error("command stream did not end on last");

   // A command list never holds more than three words.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (cnt_ff != 2'd0 && emit_ff < cnt_ff))
      else $error("emit index beyond command list");

endmodule
